### rtl/icsg_pkg.sv
// Shared types and constants of the inverted circle span generator.
package icsg_pkg;

   // Field widths fixed by the command format
   localparam int COORD_W   = 13;
   localparam int COLOR_W   = 24;
   localparam int SCREEN_W  = 12;
   localparam int CENTER_W  = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CMD_IDX_W = 3;

   // Reset values of the screen size registers
   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 12'd640;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;

   // Operation codes of the request channel
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_COLOR    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd2;

   // Draw command kinds
   typedef enum logic [1:0] {
      KIND_BOX  = 2'd0,
      KIND_LINE = 2'd1,
      KIND_DONE = 2'd2
   } cmd_kind_type;

   // Edge columns and rows of one group of four commands
   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] row_lo;
      logic signed [COORD_W-1:0] row_hi;
   } span_group_type;

endpackage

### rtl/inverted_circle_span_generator_core.sv
// Top level: midpoint circle stepper that emits the area outside a circle as draw commands.
//
//   channel   direction   handshake              carries
//   req_*     in          req_valid/req_ready    operation, centre, radius
//   rsp_*     out         rsp_valid/rsp_ready    one draw command per transaction
//   csr_*     in          csr_write_enable       fill colour, screen width, screen height
//
// A request gives 1, 4 or 8 commands, one per cycle while rsp_ready stays high; the
// single output register sets the rate.
// The next request is taken in the cycle its predecessor's final command moves
// into the output register, so requests run back to back without a gap.
// Reset is synchronous; it clears the stepper, the sequencer and the output valid flag and restores the registers.
// While rsp_ready is low and the output register holds a command, the register and the command sequencer hold.
module inverted_circle_span_generator_core
   import icsg_pkg::*;
#(
   parameter int RADIUS_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic [CENTER_W-1:0]        req_center_x,
   input  logic [CENTER_W-1:0]        req_center_y,
   input  logic [RADIUS_BITS-1:0]     req_radius,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_cmd_kind,
   output logic signed [COORD_W-1:0]  rsp_x_start,
   output logic signed [COORD_W-1:0]  rsp_y_start,
   output logic signed [COORD_W-1:0]  rsp_x_end,
   output logic signed [COORD_W-1:0]  rsp_y_end,
   output logic [COLOR_W-1:0]         rsp_draw_color,
   output logic                       rsp_last,
   // configuration port
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COLOR_W-1:0]         csr_write_data
);

   localparam int OFF_W = RADIUS_BITS + 2;
   localparam int DEC_W = RADIUS_BITS + 6;
   localparam logic signed [DEC_W-1:0] DEC_THREE = DEC_W'(3);
   localparam logic signed [DEC_W-1:0] DEC_TWO   = DEC_W'(2);
   localparam logic [CMD_IDX_W-1:0]    IDX_GROUP_END = CMD_IDX_W'(3);
   localparam logic [CMD_IDX_W-1:0]    IDX_FINAL     = CMD_IDX_W'(7);

   // configuration registers
   logic [COLOR_W-1:0]  fill_color_ff;
   logic [SCREEN_W-1:0] screen_width_ff;
   logic [SCREEN_W-1:0] screen_height_ff;

   // stepper state
   logic [CENTER_W-1:0]     saved_cx_ff, saved_cx_in;
   logic [CENTER_W-1:0]     saved_cy_ff, saved_cy_in;
   logic signed [OFF_W-1:0] major_ff, major_in;
   logic signed [OFF_W-1:0] minor_ff, minor_in;
   logic signed [DEC_W-1:0] decision_ff, decision_in;
   logic                    running_ff, running_in;

   // command sequencer
   logic                 job_valid_ff;
   cmd_kind_type         job_kind_ff;
   logic                 job_has_b_ff;
   span_group_type       job_a_ff;
   span_group_type       job_b_ff;
   logic [CMD_IDX_W-1:0] job_idx_ff;

   // output register
   logic                      out_valid_ff;
   cmd_kind_type              out_kind_ff;
   logic signed [COORD_W-1:0] out_xs_ff, out_ys_ff, out_xe_ff, out_ye_ff;
   logic [COLOR_W-1:0]        out_color_ff;
   logic                      out_last_ff;

   logic                    req_accept;
   logic                    is_start;
   logic                    do_advance;
   logic [CENTER_W-1:0]     adv_cx, adv_cy;
   logic signed [OFF_W-1:0] adv_major, adv_minor, adv_dy_a;
   logic signed [OFF_W-1:0] major_dec, minor_inc;
   logic signed [DEC_W-1:0] adv_decision, decision_mid;
   logic                    adv_take;
   span_group_type          group_a, group_b;
   cmd_kind_type            new_kind;

   logic                      out_load;
   cmd_kind_type              cmd_kind;
   logic signed [COORD_W-1:0] cmd_xs, cmd_ys, cmd_xe, cmd_ye;
   logic [COLOR_W-1:0]        cmd_color;
   logic                      cmd_last;
   span_group_type            cur_group;
   logic signed [COORD_W-1:0] edge_w, edge_h;

   // Edges of a group: columns cx-dx and cx+dx, rows cy-dy and cy+dy(+1)
   function automatic span_group_type make_group(
      input logic [CENTER_W-1:0]     cx,
      input logic [CENTER_W-1:0]     cy,
      input logic signed [OFF_W-1:0] dx,
      input logic signed [OFF_W-1:0] dy,
      input logic                    hi_plus_one
   );
      span_group_type            g;
      logic signed [COORD_W-1:0] cx_c, cy_c, dx_c, dy_c;
      cx_c     = signed'(COORD_W'(cx));
      cy_c     = signed'(COORD_W'(cy));
      dx_c     = COORD_W'(dx);
      dy_c     = COORD_W'(dy);
      g.left   = cx_c - dx_c;
      g.right  = cx_c + dx_c;
      g.row_lo = cy_c - dy_c;
      g.row_hi = cy_c + dy_c + COORD_W'(hi_plus_one);
      return g;
   endfunction

   assign req_accept = req_valid && req_ready;
   assign is_start   = (req_operation == OP_START);
   assign do_advance = is_start || running_ff;

   // Select the operands of this octant step
   always_comb begin
      if (is_start) begin
         adv_cx       = req_center_x;
         adv_cy       = req_center_y;
         adv_major    = signed'(OFF_W'(req_radius));
         adv_minor    = '0;
         adv_decision = DEC_THREE - (signed'(DEC_W'(req_radius)) <<< 1);
         adv_dy_a     = signed'(OFF_W'(req_radius));
      end else begin
         adv_cx       = saved_cx_ff;
         adv_cy       = saved_cy_ff;
         adv_major    = major_ff;
         adv_minor    = minor_ff;
         adv_decision = decision_ff;
         adv_dy_a     = minor_ff;
      end
   end

   // Update the decision term and offsets of one step
   always_comb begin
      adv_take     = ~adv_decision[DEC_W-1];
      major_dec    = adv_take ? adv_major - OFF_W'(1) : adv_major;
      minor_inc    = adv_minor + OFF_W'(1);
      decision_mid = adv_take ? adv_decision - (DEC_W'(major_dec) <<< 2) : adv_decision;
      decision_in  = decision_mid + (DEC_W'(minor_inc) <<< 2) + DEC_TWO;
      major_in     = major_dec;
      minor_in     = minor_inc;
      running_in   = (major_dec >= minor_inc);
      saved_cx_in  = adv_cx;
      saved_cy_in  = adv_cy;
   end

   // Build the command groups of the accepted transaction
   always_comb begin
      group_a = make_group(adv_cx, adv_cy, adv_major, adv_dy_a, is_start);
      group_b = make_group(adv_cx, adv_cy, adv_minor, adv_major, 1'b0);
      if (is_start) begin
         new_kind = KIND_BOX;
      end else if (running_ff) begin
         new_kind = KIND_LINE;
      end else begin
         new_kind = KIND_DONE;
      end
   end

   // Form the current command from the sequencer
   always_comb begin
      edge_w    = signed'(COORD_W'(screen_width_ff));
      edge_h    = signed'(COORD_W'(screen_height_ff));
      cur_group = job_idx_ff[2] ? job_b_ff : job_a_ff;
      cmd_kind  = job_idx_ff[2] ? KIND_LINE : job_kind_ff;
      cmd_color = fill_color_ff;
      cmd_xs    = '0;
      cmd_ys    = '0;
      cmd_xe    = '0;
      cmd_ye    = '0;
      case (cmd_kind)
         KIND_BOX: begin
            case (job_idx_ff[1:0])
               2'd0: begin
                  cmd_xe = edge_w;
                  cmd_ye = cur_group.row_lo;
               end
               2'd1: begin
                  cmd_ys = cur_group.row_lo;
                  cmd_xe = cur_group.left;
                  cmd_ye = edge_h;
               end
               2'd2: begin
                  cmd_xs = cur_group.left;
                  cmd_ys = cur_group.row_hi;
                  cmd_xe = edge_w;
                  cmd_ye = edge_h;
               end
               default: begin
                  cmd_xs = cur_group.right;
                  cmd_ys = cur_group.row_lo;
                  cmd_xe = edge_w;
                  cmd_ye = cur_group.row_hi;
               end
            endcase
         end
         KIND_LINE: begin
            cmd_ys = job_idx_ff[1] ? cur_group.row_lo : cur_group.row_hi;
            cmd_ye = cmd_ys;
            if (job_idx_ff[0]) begin
               cmd_xs = cur_group.right;
               cmd_xe = edge_w;
            end else begin
               cmd_xe = cur_group.left;
            end
         end
         default: begin
            cmd_color = '0;
         end
      endcase
      cmd_last = (cmd_kind == KIND_DONE) || (job_idx_ff == IDX_FINAL) ||
                 ((job_idx_ff == IDX_GROUP_END) && !job_has_b_ff);
   end

   assign out_load  = job_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !job_valid_ff || (out_load && cmd_last);

   // Write the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff    <= '0;
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FILL_COLOR:    fill_color_ff    <= csr_write_data;
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data[SCREEN_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_write_data[SCREEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the stepper state on each accepted start or running step
   always_ff @(posedge clock) begin
      if (reset) begin
         saved_cx_ff <= '0;
         saved_cy_ff <= '0;
         major_ff    <= '0;
         minor_ff    <= '0;
         decision_ff <= '0;
         running_ff  <= 1'b0;
      end else if (req_accept && do_advance) begin
         saved_cx_ff <= saved_cx_in;
         saved_cy_ff <= saved_cy_in;
         major_ff    <= major_in;
         minor_ff    <= minor_in;
         decision_ff <= decision_in;
         running_ff  <= running_in;
      end
   end

   // Sequencer control: load a transaction, walk its commands, drop when done
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         job_idx_ff   <= '0;
      end else if (req_accept) begin
         job_valid_ff <= 1'b1;
         job_idx_ff   <= '0;
      end else if (out_load) begin
         if (cmd_last) begin
            job_valid_ff <= 1'b0;
            job_idx_ff   <= '0;
         end else begin
            job_idx_ff <= job_idx_ff + CMD_IDX_W'(1);
         end
      end
   end

   // Sequencer payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         job_kind_ff  <= new_kind;
         job_has_b_ff <= do_advance && adv_take;
         job_a_ff     <= group_a;
         job_b_ff     <= group_b;
      end
   end

   // Output register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_kind_ff  <= cmd_kind;
         out_xs_ff    <= cmd_xs;
         out_ys_ff    <= cmd_ys;
         out_xe_ff    <= cmd_xe;
         out_ye_ff    <= cmd_ye;
         out_color_ff <= cmd_color;
         out_last_ff  <= cmd_last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cmd_kind   = out_kind_ff;
   assign rsp_x_start    = out_xs_ff;
   assign rsp_y_start    = out_ys_ff;
   assign rsp_x_end      = out_xe_ff;
   assign rsp_y_end      = out_ye_ff;
   assign rsp_draw_color = out_color_ff;
   assign rsp_last       = out_last_ff;

   // A done marker is a single command and never carries a second group
   assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && (job_kind_ff == KIND_DONE) |-> (job_idx_ff == '0) && !job_has_b_ff)
      else $error("done transaction walked past its single command");

   // A start transaction opens with the bounding boxes
   assert property (@(posedge clock) disable iff (reset)
      req_accept && is_start |=> job_valid_ff && (job_kind_ff == KIND_BOX) &&
                                 (job_idx_ff == '0))
      else $error("start transaction did not load box commands");

   // A step while idle yields the done marker
   assert property (@(posedge clock) disable iff (reset)
      req_accept && !is_start && !running_ff |=> (job_kind_ff == KIND_DONE))
      else $error("idle step did not yield a done marker");

   // A done marker always closes its transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cmd_kind == KIND_DONE) |-> rsp_last)
      else $error("done marker without last flag");

endmodule

### tb/sv/tb_inverted_circle_span_generator_core.sv
// Self-checking testbench for the inverted circle span generator core.
module tb_inverted_circle_span_generator_core
   import icsg_pkg::*;
();

   localparam int RADIUS_BITS = 10;
   localparam int ITEM_TARGET = 270;
   localparam int PHASE_ITEMS = 40;
   localparam int STALL_LIMIT = 1000;
   localparam int MAX_GAP = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // One draw command as it leaves the block
   typedef struct {
      cmd_kind_type               kind;
      logic signed [COORD_W-1:0]  xs;
      logic signed [COORD_W-1:0]  ys;
      logic signed [COORD_W-1:0]  xe;
      logic signed [COORD_W-1:0]  ye;
      logic [COLOR_W-1:0]         colour;
      logic                       last;
   } draw_cmd_type;

   // One row of the directed stimulus; typed_done marks a known done marker
   typedef struct packed {
      logic                   op;
      logic [CENTER_W-1:0]    cx;
      logic [CENTER_W-1:0]    cy;
      logic [RADIUS_BITS-1:0] r;
      logic                   typed_done;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_operation = OP_START;
   logic [CENTER_W-1:0]       req_center_x = '0;
   logic [CENTER_W-1:0]       req_center_y = '0;
   logic [RADIUS_BITS-1:0]    req_radius = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [1:0]                rsp_cmd_kind;
   logic signed [COORD_W-1:0] rsp_x_start;
   logic signed [COORD_W-1:0] rsp_y_start;
   logic signed [COORD_W-1:0] rsp_x_end;
   logic signed [COORD_W-1:0] rsp_y_end;
   logic [COLOR_W-1:0]        rsp_draw_color;
   logic                      rsp_last;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_FILL_COLOR;
   logic [COLOR_W-1:0]        csr_write_data = '0;

   inverted_circle_span_generator_core #(.RADIUS_BITS(RADIUS_BITS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cmd_kind     (rsp_cmd_kind),
      .rsp_x_start      (rsp_x_start),
      .rsp_y_start      (rsp_y_start),
      .rsp_x_end        (rsp_x_end),
      .rsp_y_end        (rsp_y_end),
      .rsp_draw_color   (rsp_draw_color),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor copy of the registers and of the stepper
   logic [COLOR_W-1:0]  colour_reg = '0;
   logic [SCREEN_W-1:0] width_reg  = SCREEN_WIDTH_RESET;
   logic [SCREEN_W-1:0] height_reg = SCREEN_HEIGHT_RESET;
   int                  ctr_x = 0;
   int                  ctr_y = 0;
   int                  major_off = 0;
   int                  minor_off = 0;
   int                  decision = 0;
   bit                  stepping = 1'b0;

   draw_cmd_type        item_cmds[$];
   draw_cmd_type        pending_cmds[$];
   int                  fail_count = 0;
   int                  items_sent = 0;
   int                  quiet_cycles = 0;
   bit                  calm = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Append one command to the commands of the current transaction
   function automatic void emit_draw(cmd_kind_type kind, int xs, int ys, int xe, int ye);
      draw_cmd_type c;
      c.kind   = kind;
      c.xs     = xs[COORD_W-1:0];
      c.ys     = ys[COORD_W-1:0];
      c.xe     = xe[COORD_W-1:0];
      c.ye     = ye[COORD_W-1:0];
      c.colour = (kind == KIND_DONE) ? '0 : colour_reg;
      c.last   = 1'b0;
      item_cmds.push_back(c);
   endfunction

   // Spans from both screen edges to the circle edge on rows y+dy and y-dy
   function automatic void emit_row_spans(int dx, int dy);
      int w;
      w = int'(width_reg);
      emit_draw(KIND_LINE, 0, ctr_y + dy, ctr_x - dx, ctr_y + dy);
      emit_draw(KIND_LINE, ctr_x + dx, ctr_y + dy, w, ctr_y + dy);
      emit_draw(KIND_LINE, 0, ctr_y - dy, ctr_x - dx, ctr_y - dy);
      emit_draw(KIND_LINE, ctr_x + dx, ctr_y - dy, w, ctr_y - dy);
   endfunction

   // Decision test and offset update of one octant step
   function automatic void octant_step();
      if (decision >= 0) begin
         emit_row_spans(minor_off, major_off);
         major_off = major_off - 1;
         decision  = decision - 4 * major_off;
      end
      minor_off = minor_off + 1;
      decision  = decision + 4 * minor_off + 2;
      stepping  = (major_off >= minor_off);
   endfunction

   // Work out every command that one accepted transaction causes
   function automatic void rasterise_item(logic op, logic [CENTER_W-1:0] cx,
                                          logic [CENTER_W-1:0] cy,
                                          logic [RADIUS_BITS-1:0] r);
      int w;
      int h;
      int rr;
      item_cmds.delete();
      w  = int'(width_reg);
      h  = int'(height_reg);
      rr = int'(r);
      if (op == OP_START) begin
         ctr_x = int'(cx);
         ctr_y = int'(cy);
         emit_draw(KIND_BOX, 0, 0, w, ctr_y - rr);
         emit_draw(KIND_BOX, 0, ctr_y - rr, ctr_x - rr, h);
         emit_draw(KIND_BOX, ctr_x - rr, ctr_y + rr + 1, w, h);
         emit_draw(KIND_BOX, ctr_x + rr, ctr_y - rr, w, ctr_y + rr + 1);
         major_off = rr;
         minor_off = 0;
         decision  = 3 - 2 * rr;
         octant_step();
      end else if (stepping) begin
         emit_row_spans(major_off, minor_off);
         octant_step();
      end else begin
         emit_draw(KIND_DONE, 0, 0, 0, 0);
      end
      item_cmds[item_cmds.size() - 1].last = 1'b1;
   endfunction

   // Offer one transaction after a random gap and queue what it should produce
   task automatic send_item(logic op, logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy,
                            logic [RADIUS_BITS-1:0] r, logic typed_done);
      int           gap;
      draw_cmd_type done_cmd;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_center_x  <= cx;
      req_center_y  <= cy;
      req_radius    <= r;
      do @(posedge clock); while (!(req_valid && req_ready));
      rasterise_item(op, cx, cy, r);
      if (typed_done) begin
         done_cmd = '{KIND_DONE, '0, '0, '0, '0, '0, 1'b1};
         pending_cmds.push_back(done_cmd);
      end else begin
         foreach (item_cmds[i]) pending_cmds.push_back(item_cmds[i]);
      end
      items_sent++;
   endtask

   task automatic send_step();
      send_item(OP_STEP, CENTER_W'($urandom), CENTER_W'($urandom),
                RADIUS_BITS'($urandom), 1'b0);
   endtask

   // Hold off the sender until every expected command has arrived
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write all three registers and one unused index, which must be ignored
   task automatic write_settings(logic [COLOR_W-1:0] colour, logic [SCREEN_W-1:0] w,
                                 logic [SCREEN_W-1:0] h);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FILL_COLOR;
      csr_write_data   <= colour;
      @(posedge clock);
      colour_reg       = colour;
      csr_index        <= CSR_SCREEN_WIDTH;
      csr_write_data   <= {12'($urandom), w};
      @(posedge clock);
      width_reg        = w;
      csr_index        <= CSR_SCREEN_HEIGHT;
      csr_write_data   <= {12'($urandom), h};
      @(posedge clock);
      height_reg       = h;
      csr_index        <= CSR_UNUSED;
      csr_write_data   <= COLOR_W'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Result side: stall for a random count before each command
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare each accepted command with the oldest expectation
   always @(posedge clock) begin : check_commands
      draw_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            $error("unexpected command: kind %0d x_start %0d y_start %0d",
                   rsp_cmd_kind, rsp_x_start, rsp_y_start);
            fail_count++;
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_cmd_kind !== want.kind) begin
               $error("cmd_kind: expected %0d, got %0d", want.kind, rsp_cmd_kind);
               fail_count++;
            end
            if (rsp_x_start !== want.xs) begin
               $error("x_start: expected %0d, got %0d", want.xs, rsp_x_start);
               fail_count++;
            end
            if (rsp_y_start !== want.ys) begin
               $error("y_start: expected %0d, got %0d", want.ys, rsp_y_start);
               fail_count++;
            end
            if (rsp_x_end !== want.xe) begin
               $error("x_end: expected %0d, got %0d", want.xe, rsp_x_end);
               fail_count++;
            end
            if (rsp_y_end !== want.ye) begin
               $error("y_end: expected %0d, got %0d", want.ye, rsp_y_end);
               fail_count++;
            end
            if (rsp_draw_color !== want.colour) begin
               $error("draw_color: expected %06h, got %06h", want.colour, rsp_draw_color);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: count cycles in which no transaction or register write happens
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus: directed table under reset settings, then random phases
   initial begin
      stim_row_type           directed_rows [0:23];
      int                     phase;
      int                     phase_end;
      int                     pick;
      int                     steps;
      logic [COLOR_W-1:0]     colour;
      logic [SCREEN_W-1:0]    w;
      logic [SCREEN_W-1:0]    h;
      logic [RADIUS_BITS-1:0] rad;

      directed_rows = '{
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b1},  // step straight after reset
         '{OP_START, 11'd0,    11'd0,    10'd0,    1'b0},  // zero radius at the origin
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b1},  // zero radius is already over
         '{OP_START, 11'd2047, 11'd2047, 10'd1023, 1'b0},  // largest centre and radius
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_START, 11'd1024, 11'd512,  10'd1,    1'b0},  // drop the running circle
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b1},  // unit radius ends on start
         '{OP_START, 11'd300,  11'd200,  10'd5,    1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_START, 11'd5,    11'd3,    10'd20,   1'b0},  // boxes reach negative columns
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_START, 11'h555,  11'h2AA,  10'h2AA,  1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_START, 11'h2AA,  11'h555,  10'h155,  1'b0},
         '{OP_STEP,  11'd0,    11'd0,    10'd0,    1'b0},
         '{OP_STEP,  11'h7FF,  11'h7FF,  10'h3FF,  1'b0}   // step fields are ignored
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].cx, directed_rows[i].cy,
                   directed_rows[i].r, directed_rows[i].typed_done);
      wait_for_idle();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         // Pick the register settings of this phase: both extremes first
         case (phase % 4)
            0: begin
               colour = 24'hFFFFFF;
               w      = 12'd4095;
               h      = 12'd4095;
            end
            1: begin
               colour = 24'h000000;
               w      = 12'd1;
               h      = 12'd1;
            end
            default: begin
               colour = COLOR_W'($urandom);
               w      = SCREEN_W'($urandom_range(1, 4095));
               h      = SCREEN_W'($urandom_range(1, 4095));
            end
         endcase
         write_settings(colour, w, h);

         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
               // Whole circle: mostly small, now and then any radius
               if ($urandom_range(0, 7) == 0)
                  rad = RADIUS_BITS'($urandom);
               else
                  rad = RADIUS_BITS'($urandom_range(0, 24));
               send_item(OP_START, CENTER_W'($urandom), CENTER_W'($urandom), rad, 1'b0);
               steps = 0;
               while (stepping && steps < 24) begin
                  send_step();
                  steps++;
               end
               if ($urandom_range(0, 1) == 1) send_step();
            end else if (pick == 7) begin
               // Noise: any operation with any fields
               repeat ($urandom_range(1, 3))
                  send_item(1'($urandom), CENTER_W'($urandom), CENTER_W'($urandom),
                            RADIUS_BITS'($urandom), 1'b0);
            end else begin
               // Broken circle: start, a few steps, then leave it for the next start
               send_item(OP_START, CENTER_W'($urandom), CENTER_W'($urandom),
                         RADIUS_BITS'($urandom), 1'b0);
               repeat ($urandom_range(0, 3)) send_step();
            end
         end
         calm = 1'b0;
         wait_for_idle();
         phase++;
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_cmds.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/icsg_pkg.sv
rtl/inverted_circle_span_generator_core.sv
tb/sv/tb_inverted_circle_span_generator_core.sv
